// File: hw/rtl/lbmp_pkg.sv
// ----------------------------------------------------------------------------
// lbmp_pkg
// shared types for the lucas binomial mod prime core
// ----------------------------------------------------------------------------
package lbmp_pkg;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIGIT,
      ST_DIGWAIT,
      ST_CHECK,
      ST_TERM,
      ST_POWSTEP,
      ST_INVMUL,
      ST_DIGMUL,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_RUN,
      DIV_DONE
   } div_state_type;

endpackage

// File: hw/rtl/lucas_binomial_mod_prime_core.sv
// ----------------------------------------------------------------------------
// lucas_binomial_mod_prime_core
// binomial coefficient modulo a prime by lucas's theorem, one shared divider
// ----------------------------------------------------------------------------
// per base-p digit pair, two DIV_BITS-bit divisions for the digits
// (DIV_BITS is the larger of COUNT_BITS and 2*MOD_BITS), then per falling term
// up to (2 + 2*MOD_BITS) divisions
// throughput: one beat at a time, ready only in idle; the shared divider sets
// the pace. synchronous reset returns the sequencer to idle, no result pending
module lucas_binomial_mod_prime_core #(
   parameter int COUNT_BITS = 60,
   parameter int MOD_BITS   = 17
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [COUNT_BITS-1:0] req_top_count,
   input  logic [COUNT_BITS-1:0] req_choose_count,
   input  logic [MOD_BITS-1:0]   req_prime_modulus,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [MOD_BITS-1:0]   rsp_binom_mod
);

   localparam int PROD_BITS = 2 * MOD_BITS;
   localparam int DIV_BITS  = (COUNT_BITS > PROD_BITS) ? COUNT_BITS : PROD_BITS;

   lbmp_pkg::state_type state_ff, state_in;

   logic [COUNT_BITS-1:0] n_ff, n_in, k_ff, k_in;
   logic [MOD_BITS-1:0]   m_ff, m_in;
   logic [MOD_BITS-1:0]   acc_ff, acc_in;     // overall product
   logic [MOD_BITS-1:0]   sb_ff, sb_in;       // small binomial
   logic [MOD_BITS-1:0]   dn_ff, dn_in, dk_ff, dk_in;
   logic [MOD_BITS-1:0]   i_ff, i_in;
   logic [MOD_BITS-1:0]   base_ff, base_in, pacc_ff, pacc_in;
   logic [MOD_BITS-1:0]   exp_ff, exp_in;
   logic [1:0]            phase_ff, phase_in;  // power sub-op select
   logic                  kdig_ff, kdig_in;
   logic [MOD_BITS-1:0]   res_ff, res_in;
   logic                  busy_ff, busy_in;

   logic                  div_start;
   logic [DIV_BITS-1:0]   div_numer;
   logic                  div_done;
   logic [DIV_BITS-1:0]   div_quot;
   logic [MOD_BITS-1:0]   div_rem;

   logic [PROD_BITS-1:0]  mul_a, mul_b, prod;

   lbmp_divider #(.NUM_BITS(DIV_BITS), .DEN_BITS(MOD_BITS)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_numer),
      .denom (m_ff),
      .done  (div_done),
      .quot  (div_quot),
      .rem   (div_rem)
   );

   assign prod = mul_a * mul_b;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lbmp_pkg::ST_IDLE:
            if (req_valid && !busy_ff) state_in = lbmp_pkg::ST_DIGIT;
         lbmp_pkg::ST_DIGIT:
            if (m_ff < MOD_BITS'(2) || (n_ff == '0 && k_ff == '0))
               state_in = lbmp_pkg::ST_DONE;
            else
               state_in = lbmp_pkg::ST_DIGWAIT;
         lbmp_pkg::ST_DIGWAIT:
            if (div_done && kdig_ff) state_in = lbmp_pkg::ST_CHECK;
         lbmp_pkg::ST_CHECK:
            if (dk_ff > dn_ff)      state_in = lbmp_pkg::ST_DONE;
            else if (i_ff > dk_ff)  state_in = lbmp_pkg::ST_DIGMUL;
            else                    state_in = lbmp_pkg::ST_TERM;
         lbmp_pkg::ST_TERM:
            if (div_done) state_in = lbmp_pkg::ST_POWSTEP;
         lbmp_pkg::ST_POWSTEP:
            if (exp_ff == '0) state_in = lbmp_pkg::ST_INVMUL;
         lbmp_pkg::ST_INVMUL:
            if (div_done) state_in = lbmp_pkg::ST_CHECK;
         lbmp_pkg::ST_DIGMUL:
            if (div_done) state_in = lbmp_pkg::ST_DIGIT;
         lbmp_pkg::ST_DONE:
            state_in = lbmp_pkg::ST_IDLE;
         default:
            state_in = lbmp_pkg::ST_IDLE;
      endcase
   end

   // datapath and divider control
   always_comb begin
      n_in = n_ff;  k_in = k_ff;  m_in = m_ff;
      acc_in = acc_ff;  sb_in = sb_ff;  dn_in = dn_ff;  dk_in = dk_ff;
      i_in = i_ff;  base_in = base_ff;  pacc_in = pacc_ff;  exp_in = exp_ff;
      phase_in = phase_ff;  kdig_in = kdig_ff;  res_in = res_ff;
      busy_in = busy_ff;
      div_start = 1'b0;
      div_numer = '0;
      mul_a = '0;
      mul_b = '0;
      if (rsp_valid && rsp_ready) busy_in = 1'b0;
      case (state_ff)
         lbmp_pkg::ST_IDLE: begin
            if (req_valid && !busy_ff) begin
               n_in = req_top_count;
               k_in = req_choose_count;
               m_in = req_prime_modulus;
               acc_in = MOD_BITS'(1);
            end
         end
         lbmp_pkg::ST_DIGIT: begin
            kdig_in = 1'b0;
            if (!(m_ff < MOD_BITS'(2) || (n_ff == '0 && k_ff == '0))) begin
               div_start = 1'b1;
               div_numer = DIV_BITS'(n_ff);
            end
         end
         lbmp_pkg::ST_DIGWAIT: begin
            if (div_done) begin
               if (!kdig_ff) begin
                  dn_in = div_rem;
                  n_in = div_quot[COUNT_BITS-1:0];
                  kdig_in = 1'b1;
                  div_start = 1'b1;
                  div_numer = DIV_BITS'(k_ff);
               end else begin
                  dk_in = div_rem;
                  k_in = div_quot[COUNT_BITS-1:0];
                  sb_in = MOD_BITS'(1);
                  i_in = MOD_BITS'(1);
               end
            end
         end
         lbmp_pkg::ST_CHECK: begin
            if (dk_ff > dn_ff) begin
               acc_in = '0;
            end else if (i_ff > dk_ff) begin
               mul_a = PROD_BITS'(acc_ff);
               mul_b = PROD_BITS'(sb_ff);
               div_start = 1'b1;
               div_numer = DIV_BITS'(prod);
            end else begin
               // dn - i + 1 is already below m
               mul_a = PROD_BITS'(sb_ff);
               mul_b = PROD_BITS'(dn_ff - i_ff + MOD_BITS'(1));
               div_start = 1'b1;
               div_numer = DIV_BITS'(prod);
            end
         end
         lbmp_pkg::ST_TERM: begin
            if (div_done) begin
               sb_in = div_rem;
               base_in = i_ff;
               pacc_in = MOD_BITS'(1);
               exp_in = m_ff - MOD_BITS'(2);
               phase_in = 2'd0;
            end
         end
         lbmp_pkg::ST_POWSTEP: begin
            // phase 0 issue, 1 wait acc multiply, 2 wait square
            case (phase_ff)
               2'd0: begin
                  if (exp_ff != '0) begin
                     div_start = 1'b1;
                     if (exp_ff[0]) begin
                        mul_a = PROD_BITS'(pacc_ff);
                        mul_b = PROD_BITS'(base_ff);
                        phase_in = 2'd1;
                     end else begin
                        mul_a = PROD_BITS'(base_ff);
                        mul_b = PROD_BITS'(base_ff);
                        phase_in = 2'd2;
                     end
                     div_numer = DIV_BITS'(prod);
                  end else begin
                     mul_a = PROD_BITS'(sb_ff);
                     mul_b = PROD_BITS'(pacc_ff);
                     div_start = 1'b1;
                     div_numer = DIV_BITS'(prod);
                  end
               end
               2'd1: begin
                  if (div_done) begin
                     pacc_in = div_rem;
                     mul_a = PROD_BITS'(base_ff);
                     mul_b = PROD_BITS'(base_ff);
                     div_start = 1'b1;
                     div_numer = DIV_BITS'(prod);
                     phase_in = 2'd2;
                  end
               end
               default: begin
                  if (div_done) begin
                     base_in = div_rem;
                     exp_in = exp_ff >> 1;
                     phase_in = 2'd0;
                  end
               end
            endcase
         end
         lbmp_pkg::ST_INVMUL: begin
            if (div_done) begin
               sb_in = div_rem;
               i_in = i_ff + MOD_BITS'(1);
            end
         end
         lbmp_pkg::ST_DIGMUL: begin
            if (div_done) acc_in = div_rem;
         end
         lbmp_pkg::ST_DONE: begin
            res_in = (m_ff < MOD_BITS'(2)) ? '0 : acc_ff;
            busy_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lbmp_pkg::ST_IDLE;
         busy_ff  <= 1'b0;
         phase_ff <= 2'd0;
         kdig_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
         phase_ff <= phase_in;
         kdig_ff  <= kdig_in;
      end
      n_ff <= n_in;  k_ff <= k_in;  m_ff <= m_in;
      acc_ff <= acc_in;  sb_ff <= sb_in;  dn_ff <= dn_in;  dk_ff <= dk_in;
      i_ff <= i_in;  base_ff <= base_in;  pacc_ff <= pacc_in;  exp_ff <= exp_in;
      res_ff <= res_in;
   end

   assign req_ready     = (state_ff == lbmp_pkg::ST_IDLE) && !busy_ff;
   assign rsp_valid     = busy_ff;
   assign rsp_binom_mod = res_ff;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !req_ready)
      else $error("input taken while result pending");
   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_binom_mod)))
      else $error("result dropped");
   a_digit_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lbmp_pkg::ST_CHECK) |-> (dn_ff < m_ff && dk_ff < m_ff))
      else $error("digit not reduced");

endmodule

// File: hw/rtl/lbmp_divider.sv
// ----------------------------------------------------------------------------
// lbmp_divider
// restoring divider, one quotient bit per cycle, quotient and remainder
// ----------------------------------------------------------------------------
module lbmp_divider #(
   parameter int NUM_BITS = 64,
   parameter int DEN_BITS = 31
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NUM_BITS-1:0] numer,
   input  logic [DEN_BITS-1:0] denom,
   output logic                done,
   output logic [NUM_BITS-1:0] quot,
   output logic [DEN_BITS-1:0] rem
);

   localparam int CNT_BITS = $clog2(NUM_BITS + 1);

   lbmp_pkg::div_state_type state_ff, state_in;
   logic [NUM_BITS-1:0] quot_ff, quot_in;
   logic [DEN_BITS:0]   rem_ff, rem_in;
   logic [DEN_BITS-1:0] den_ff, den_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [DEN_BITS:0]   trial;

   always_comb begin
      trial = {rem_ff[DEN_BITS-1:0], quot_ff[NUM_BITS-1]};
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lbmp_pkg::DIV_IDLE: if (start) state_in = lbmp_pkg::DIV_RUN;
         lbmp_pkg::DIV_RUN:  if (cnt_ff == CNT_BITS'(1)) state_in = lbmp_pkg::DIV_DONE;
         lbmp_pkg::DIV_DONE: begin
            // a new division may be issued in the cycle the last one completes
            if (start) state_in = lbmp_pkg::DIV_RUN;
            else       state_in = lbmp_pkg::DIV_IDLE;
         end
         default:            state_in = lbmp_pkg::DIV_IDLE;
      endcase
   end

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      if ((state_ff inside {lbmp_pkg::DIV_IDLE, lbmp_pkg::DIV_DONE}) && start) begin
         quot_in = numer;
         rem_in  = '0;
         den_in  = denom;
         cnt_in  = CNT_BITS'(NUM_BITS);
      end else if (state_ff == lbmp_pkg::DIV_RUN) begin
         cnt_in = cnt_ff - CNT_BITS'(1);
         if (trial >= {1'b0, den_ff}) begin
            rem_in  = trial - {1'b0, den_ff};
            quot_in = {quot_ff[NUM_BITS-2:0], 1'b1};
         end else begin
            rem_in  = trial;
            quot_in = {quot_ff[NUM_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lbmp_pkg::DIV_IDLE;
      end else begin
         state_ff <= state_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      cnt_ff  <= cnt_in;
   end

   assign done = (state_ff == lbmp_pkg::DIV_DONE);
   assign quot = quot_ff;
   assign rem  = rem_ff[DEN_BITS-1:0];

   a_rem_below: assert property (@(posedge clock) disable iff (reset)
      done |-> (rem_ff < {1'b0, den_ff}))
      else $error("remainder not reduced");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lbmp_pkg::DIV_RUN) |=> (state_ff != lbmp_pkg::DIV_IDLE))
      else $error("divider left run early");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done |=> !done)
      else $error("done held");

endmodule
